// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define GAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define GAP_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define GAP_ASSERT(lbl, prop, msg)
`define GAP_ASSERT_NEXT(lbl, cond, cons, msg)
`endif
`endif

// ===== rtl/gap_pkg.sv =====
// Types, constants and helper functions of the grid path search.
`default_nettype none
package gap_pkg;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int HEAP_DEPTH = 16384;
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int CELL_AW    = X_BITS + Y_BITS;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int HEAP_CW    = HEAP_AW + 1;
    localparam int COST_W     = 13;
    localparam int SEQ_W      = 15;

    localparam logic [COST_W-1:0] COST_INF = '1;

    // Input modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Neighbor directions, in search order
    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_XM = 2'd1;
    localparam logic [1:0] DIR_YP = 2'd2;
    localparam logic [1:0] DIR_YM = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic        cell_open;
        logic [5:0]  start_x;
        logic [5:0]  start_y;
        logic [5:0]  goal_x;
        logic [5:0]  goal_y;
        logic [11:0] step_index;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [12:0] path_length;
        logic [5:0]  step_x;
        logic [5:0]  step_y;
    } t_out_word;

    typedef struct packed {
        logic [COST_W-1:0]  f;
        logic [SEQ_W-1:0]   seq;
        logic [CELL_AW-1:0] loc;
    } t_heap_ent;

    typedef struct packed {
        logic              closed;
        logic [COST_W-1:0] cost;
        logic [1:0]        dir;
    } t_node;

    // Order heap entries by f, then by insertion order.
    function automatic logic ent_less(input t_heap_ent a, input t_heap_ent b);
        return (a.f < b.f) || ((a.f == b.f) && (a.seq < b.seq));
    endfunction

    // Manhattan distance between two cells.
    function automatic logic [COST_W-1:0] manhattan(input logic [X_BITS-1:0] ax,
                                                    input logic [Y_BITS-1:0] ay,
                                                    input logic [X_BITS-1:0] bx,
                                                    input logic [Y_BITS-1:0] by);
        logic [X_BITS-1:0] dx;
        logic [Y_BITS-1:0] dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return COST_W'(dx) + COST_W'(dy);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/grid_astar_path_search.sv =====
// Top level of the grid A* path search: grid, node table, open heap, path store.
//
// Channel | Direction | Handshake          | Word
// in      | input     | i_in_valid/o_in_stall   | gap_pkg::t_in_word
// out     | output    | o_out_valid/i_out_stall | gap_pkg::t_out_word
// cfg     | input     | i_cfg_valid/o_cfg_ready | index 1 bit, data 7 bits
//
// After reset the grid is swept to blocked; no word is taken then.
// A cell write or path read goes through its own state to the response; a search
// clears the node table, then each heap pop sifts down level by level, each
// neighbor may push an entry with a sift-up, and the path trace steps back one
// cell at a time. The heap memory accesses set the pace of a search.
// One word is taken at a time; the result waits in the output register.
`default_nettype none
`include "assert_macros.svh"
module grid_astar_path_search (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gap_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gap_pkg::t_out_word      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [6:0]         i_cfg_data
);
    typedef enum logic [23:0] {
        S_IDLE = 24'b1 << 0,
        S_INIT = 24'b1 << 1,
        S_WRC  = 24'b1 << 2,
        S_RDP  = 24'b1 << 3,
        S_SRCH = 24'b1 << 4,
        S_CHKG = 24'b1 << 5,
        S_CLR  = 24'b1 << 6,
        S_NXT  = 24'b1 << 7,
        S_POP0 = 24'b1 << 8,
        S_POP1 = 24'b1 << 9,
        S_POP2 = 24'b1 << 10,
        S_SD0  = 24'b1 << 11,
        S_SD1  = 24'b1 << 12,
        S_SD2  = 24'b1 << 13,
        S_SD3  = 24'b1 << 14,
        S_EX0  = 24'b1 << 15,
        S_EX1  = 24'b1 << 16,
        S_NB0  = 24'b1 << 17,
        S_NB1  = 24'b1 << 18,
        S_PU0  = 24'b1 << 19,
        S_PU1  = 24'b1 << 20,
        S_TR0  = 24'b1 << 21,
        S_TR1  = 24'b1 << 22,
        S_RESP = 24'b1 << 23
    } t_state;

    localparam int XB = gap_pkg::X_BITS;
    localparam int YB = gap_pkg::Y_BITS;
    localparam int AW = gap_pkg::CELL_AW;
    localparam int HA = gap_pkg::HEAP_AW;
    localparam int HC = gap_pkg::HEAP_CW;
    localparam int CW = gap_pkg::COST_W;
    localparam int SW = gap_pkg::SEQ_W;
    localparam logic [6:0] W_MAX = 7'(gap_pkg::MAX_WIDTH);
    localparam logic [6:0] H_MAX = 7'(gap_pkg::MAX_HEIGHT);
    localparam logic [HC-1:0] H_DEPTH = HC'(gap_pkg::HEAP_DEPTH);
    localparam logic CFG_W_SEL = gap_pkg::CFG_WIDTH;

    // Memories
    logic               grid_mem [gap_pkg::CELLS];
    gap_pkg::t_node     node_mem [gap_pkg::CELLS];
    gap_pkg::t_heap_ent heap_mem [gap_pkg::HEAP_DEPTH];
    logic [AW-1:0]      path_mem [gap_pkg::CELLS];

    logic               grid_we, grid_wd, grid_rd;
    logic [AW-1:0]      grid_wa, grid_ra;
    logic               node_we;
    logic [AW-1:0]      node_wa, node_ra;
    gap_pkg::t_node     node_wd, node_rd;
    logic               heap_we;
    logic [HA-1:0]      heap_wa, heap_ra;
    gap_pkg::t_heap_ent heap_wd, heap_rd;
    logic               path_we;
    logic [AW-1:0]      path_wa, path_ra, path_wd, path_rd;

    // Registers
    t_state             r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [6:0]         r_w, r_h;
    gap_pkg::t_in_word  r_item, n_item;
    logic               r_found, n_found;
    logic [12:0]        r_len, n_len;
    logic [HC-1:0]      r_hcount, n_hcount;
    logic [SW-1:0]      r_seq, n_seq;
    gap_pkg::t_heap_ent r_top, n_top, r_last, n_last, r_ch, n_ch, r_e, n_e;
    logic [HA-1:0]      r_i, n_i;
    logic [HC-1:0]      r_c, n_c;
    logic [CW-1:0]      r_gcur, n_gcur;
    logic [1:0]         r_d, n_d;
    logic [AW-1:0]      r_n, n_n, r_at, n_at;
    logic [12:0]        r_pos, n_pos;
    logic [5:0]         r_sx, n_sx, r_sy, n_sy;
    logic               r_out_valid, n_out_valid;
    gap_pkg::t_out_word r_out, n_out;

    logic               in_acc;
    logic [6:0]         w_eff, h_eff;
    logic [AW-1:0]      start_cell, goal_cell;
    logic [XB-1:0]      cur_x, nb_x;
    logic [YB-1:0]      cur_y, nb_y;
    logic               nb_ok;
    logic [CW-1:0]      g_new;
    logic [HC-1:0]      c_left;
    logic [HC:0]        c_right;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_eff      = (r_w > W_MAX) ? W_MAX : r_w;
    assign h_eff      = (r_h > H_MAX) ? H_MAX : r_h;
    assign start_cell = {r_item.start_y, r_item.start_x};
    assign goal_cell  = {r_item.goal_y, r_item.goal_x};
    assign cur_x      = r_top.loc[XB-1:0];
    assign cur_y      = r_top.loc[AW-1:XB];
    assign g_new      = r_gcur + CW'(1);
    assign c_left     = {r_i, 1'b1};
    assign c_right    = {1'b0, r_c} + (HC+1)'(1);

    // Pick the neighbor for the current direction
    always_comb begin
        nb_x  = cur_x;
        nb_y  = cur_y;
        nb_ok = 1'b0;
        unique case (r_d)
            gap_pkg::DIR_XP: begin
                nb_ok = (7'(cur_x) + 7'd1) < w_eff;
                nb_x  = cur_x + XB'(1);
            end
            gap_pkg::DIR_XM: begin
                nb_ok = (cur_x != '0);
                nb_x  = cur_x - XB'(1);
            end
            gap_pkg::DIR_YP: begin
                nb_ok = (7'(cur_y) + 7'd1) < h_eff;
                nb_y  = cur_y + YB'(1);
            end
            gap_pkg::DIR_YM: begin
                nb_ok = (cur_y != '0);
                nb_y  = cur_y - YB'(1);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // Sequence the search
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_item   = r_item;
        n_found  = r_found;
        n_len    = r_len;
        n_hcount = r_hcount;
        n_seq    = r_seq;
        n_top    = r_top;
        n_last   = r_last;
        n_ch     = r_ch;
        n_e      = r_e;
        n_i      = r_i;
        n_c      = r_c;
        n_gcur   = r_gcur;
        n_d      = r_d;
        n_n      = r_n;
        n_at     = r_at;
        n_pos    = r_pos;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_out    = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        grid_we = 1'b0; grid_wa = '0; grid_wd = 1'b0; grid_ra = '0;
        node_we = 1'b0; node_wa = '0; node_wd = '0;   node_ra = '0;
        heap_we = 1'b0; heap_wa = '0; heap_wd = '0;   heap_ra = '0;
        path_we = 1'b0; path_wa = '0; path_wd = '0;
        path_ra = i_in_data.step_index;

        unique case (r_state)
            S_IDLE: begin
                grid_ra = {i_in_data.start_y, i_in_data.start_x};
                n_sx = '0;
                n_sy = '0;
                if (in_acc) begin
                    n_item = i_in_data;
                    unique case (i_in_data.mode)
                        gap_pkg::MODE_WRITE:  n_state = S_WRC;
                        gap_pkg::MODE_SEARCH: n_state = S_SRCH;
                        gap_pkg::MODE_READ:   n_state = S_RDP;
                        default:              n_state = S_RESP;
                    endcase
                end
            end
            S_INIT: begin
                grid_we = 1'b1;
                grid_wa = r_cnt;
                grid_wd = 1'b0;
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == '1) n_state = S_IDLE;
            end
            S_WRC: begin
                grid_we = 1'b1;
                grid_wa = {r_item.cell_y, r_item.cell_x};
                grid_wd = r_item.cell_open;
                n_state = S_RESP;
            end
            S_RDP: begin
                if (13'(r_item.step_index) < r_len) begin
                    n_sx = path_rd[XB-1:0];
                    n_sy = path_rd[AW-1:XB];
                end
                n_state = S_RESP;
            end
            S_SRCH: begin
                n_found  = 1'b0;
                n_len    = '0;
                n_hcount = '0;
                n_seq    = '0;
                grid_ra  = goal_cell;
                if ((7'(r_item.start_x) >= w_eff) || (7'(r_item.start_y) >= h_eff) ||
                    (7'(r_item.goal_x) >= w_eff) || (7'(r_item.goal_y) >= h_eff) ||
                    !grid_rd) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_CHKG;
                end
            end
            S_CHKG: begin
                n_cnt   = '0;
                n_state = grid_rd ? S_CLR : S_RESP;
            end
            S_CLR: begin
                // Sweep the node table; the start gets cost zero
                node_we = 1'b1;
                node_wa = r_cnt;
                node_wd = '{closed: 1'b0, cost: (r_cnt == start_cell) ? '0 : gap_pkg::COST_INF,
                            dir: gap_pkg::DIR_XP};
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == '1) begin
                    n_e = '{f: gap_pkg::manhattan(r_item.start_x, r_item.start_y,
                                                  r_item.goal_x, r_item.goal_y),
                            seq: '0, loc: start_cell};
                    n_seq    = SW'(1);
                    n_hcount = HC'(1);
                    n_i      = '0;
                    n_d      = gap_pkg::DIR_YM;
                    n_state  = S_PU0;
                end
            end
            S_NXT: begin
                if (r_d == gap_pkg::DIR_YM) begin
                    n_state = S_POP0;
                end else begin
                    n_d     = r_d + 2'd1;
                    n_state = S_NB0;
                end
            end
            S_POP0: begin
                heap_ra = '0;
                n_state = (r_hcount == '0) ? S_RESP : S_POP1;
            end
            S_POP1: begin
                n_top    = heap_rd;
                heap_ra  = HA'(r_hcount - HC'(1));
                n_hcount = r_hcount - HC'(1);
                n_state  = S_POP2;
            end
            S_POP2: begin
                n_last  = heap_rd;
                n_i     = '0;
                n_state = S_SD0;
            end
            S_SD0: begin
                if (c_left >= r_hcount) begin
                    if (r_hcount != '0) begin
                        heap_we = 1'b1;
                        heap_wa = r_i;
                        heap_wd = r_last;
                    end
                    n_state = S_EX0;
                end else begin
                    heap_ra = c_left[HA-1:0];
                    n_c     = c_left;
                    n_state = S_SD1;
                end
            end
            S_SD1: begin
                n_ch = heap_rd;
                if (c_right < {1'b0, r_hcount}) begin
                    heap_ra = c_right[HA-1:0];
                    n_state = S_SD2;
                end else begin
                    n_state = S_SD3;
                end
            end
            S_SD2: begin
                if (gap_pkg::ent_less(heap_rd, r_ch)) begin
                    n_ch = heap_rd;
                    n_c  = c_right[HC-1:0];
                end
                n_state = S_SD3;
            end
            S_SD3: begin
                heap_we = 1'b1;
                heap_wa = r_i;
                if (gap_pkg::ent_less(r_ch, r_last)) begin
                    heap_wd = r_ch;
                    n_i     = r_c[HA-1:0];
                    n_state = S_SD0;
                end else begin
                    heap_wd = r_last;
                    n_state = S_EX0;
                end
            end
            S_EX0: begin
                node_ra = r_top.loc;
                n_state = S_EX1;
            end
            S_EX1: begin
                if (node_rd.closed) begin
                    n_state = S_POP0;
                end else begin
                    node_we = 1'b1;
                    node_wa = r_top.loc;
                    node_wd = '{closed: 1'b1, cost: node_rd.cost, dir: node_rd.dir};
                    n_gcur  = node_rd.cost;
                    if (r_top.loc == goal_cell) begin
                        n_pos   = node_rd.cost + 13'd1;
                        n_at    = goal_cell;
                        n_state = S_TR0;
                    end else begin
                        n_d     = gap_pkg::DIR_XP;
                        n_state = S_NB0;
                    end
                end
            end
            S_NB0: begin
                if (nb_ok) begin
                    n_n     = {nb_y, nb_x};
                    grid_ra = {nb_y, nb_x};
                    node_ra = {nb_y, nb_x};
                    n_state = S_NB1;
                end else begin
                    n_state = S_NXT;
                end
            end
            S_NB1: begin
                n_state = S_NXT;
                if (grid_rd && !node_rd.closed && (g_new < node_rd.cost)) begin
                    node_we = 1'b1;
                    node_wa = r_n;
                    node_wd = '{closed: 1'b0, cost: g_new, dir: r_d};
                    // Drop the push when the heap is full
                    if (r_hcount < H_DEPTH) begin
                        n_e = '{f: g_new + gap_pkg::manhattan(r_n[XB-1:0], r_n[AW-1:XB],
                                                             r_item.goal_x, r_item.goal_y),
                                seq: r_seq, loc: r_n};
                        n_seq    = r_seq + SW'(1);
                        n_i      = r_hcount[HA-1:0];
                        n_hcount = r_hcount + HC'(1);
                        n_state  = S_PU0;
                    end
                end
            end
            S_PU0: begin
                if (r_i == '0) begin
                    heap_we = 1'b1;
                    heap_wa = '0;
                    heap_wd = r_e;
                    n_state = S_NXT;
                end else begin
                    heap_ra = (r_i - HA'(1)) >> 1;
                    n_state = S_PU1;
                end
            end
            S_PU1: begin
                heap_we = 1'b1;
                heap_wa = r_i;
                if (gap_pkg::ent_less(r_e, heap_rd)) begin
                    heap_wd = heap_rd;
                    n_i     = (r_i - HA'(1)) >> 1;
                    n_state = S_PU0;
                end else begin
                    heap_wd = r_e;
                    n_state = S_NXT;
                end
            end
            S_TR0: begin
                path_we = 1'b1;
                path_wa = AW'(r_pos - 13'd1);
                path_wd = r_at;
                node_ra = r_at;
                n_pos   = r_pos - 13'd1;
                if ((r_at == start_cell) || (r_pos == 13'd1)) begin
                    n_found = 1'b1;
                    n_len   = r_gcur + 13'd1;
                    n_state = S_RESP;
                end else begin
                    n_state = S_TR1;
                end
            end
            S_TR1: begin
                // Step back toward the parent
                unique case (node_rd.dir)
                    gap_pkg::DIR_XP: n_at = {r_at[AW-1:XB], r_at[XB-1:0] - XB'(1)};
                    gap_pkg::DIR_XM: n_at = {r_at[AW-1:XB], r_at[XB-1:0] + XB'(1)};
                    gap_pkg::DIR_YP: n_at = {r_at[AW-1:XB] - YB'(1), r_at[XB-1:0]};
                    gap_pkg::DIR_YM: n_at = {r_at[AW-1:XB] + YB'(1), r_at[XB-1:0]};
                    default:         n_at = r_at;
                endcase
                n_state = S_TR0;
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out = '{found: r_found, path_length: r_len, step_x: r_sx, step_y: r_sy};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_w         <= W_MAX;
            r_h         <= H_MAX;
            r_found     <= 1'b0;
            r_len       <= '0;
            r_hcount    <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_len       <= n_len;
            r_hcount    <= n_hcount;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_W_SEL: r_w <= i_cfg_data;
                    default:   r_h <= i_cfg_data;
                endcase
            end
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_top  <= n_top;
        r_last <= n_last;
        r_ch   <= n_ch;
        r_e    <= n_e;
        r_i    <= n_i;
        r_c    <= n_c;
        r_gcur <= n_gcur;
        r_d    <= n_d;
        r_n    <= n_n;
        r_at   <= n_at;
        r_pos  <= n_pos;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_out  <= n_out;
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (grid_we) grid_mem[grid_wa] <= grid_wd;
        grid_rd <= grid_mem[grid_ra];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) node_mem[node_wa] <= node_wd;
        node_rd <= node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) heap_mem[heap_wa] <= heap_wd;
        heap_rd <= heap_mem[heap_ra];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) path_mem[path_wa] <= path_wd;
        path_rd <= path_mem[path_ra];
    end

    `GAP_ASSERT(a_heap_bound, r_hcount <= H_DEPTH, "heap count beyond depth")
    `GAP_ASSERT(a_found_len, !r_found || (r_len != '0), "found with zero path length")
    `GAP_ASSERT_NEXT(a_accept_busy, in_acc, r_state != S_IDLE, "idle after accepting a word")
    `GAP_ASSERT_NEXT(a_resp_hold, (r_state == S_RESP) && r_out_valid && i_out_stall,
                     r_state == S_RESP, "result dropped while output is stalled")
endmodule
`default_nettype wire
